>>> rtl/cc20_pkg.sv
// ChaCha20 byte-stream cipher: shared constants, types and round function.
// No dependencies.
package cc20_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned PosW       = $clog2(BlockBytes);
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned QDepth     = 2;

  localparam logic [CfgIdxW-1:0] RegKey01   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey23   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey45   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey67   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNonce01 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegNonce2  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegStart   = 3'd6;

  localparam logic [31:0] Sigma0 = 32'h6170_7865;
  localparam logic [31:0] Sigma1 = 32'h3320_646E;
  localparam logic [31:0] Sigma2 = 32'h7962_2D32;
  localparam logic [31:0] Sigma3 = 32'h6B20_6574;

  typedef logic [15:0][31:0] state_t;

  // classified word passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       new_blk;   // first byte of a block: keystream must be swapped in
  } qword_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  // one quarter round on four words
  function automatic logic [127:0] qround(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] ta, tb, tc, td;
    ta = a + b;  td = rotl(d ^ ta, 16);
    tc = c + td; tb = rotl(b ^ tc, 12);
    ta = ta + tb; td = rotl(td ^ ta, 8);
    tc = tc + td; tb = rotl(tb ^ tc, 7);
    qround = {ta, tb, tc, td};
  endfunction

endpackage

>>> rtl/cc20_core.sv
// ChaCha20 block generator: one column or diagonal half-round per cycle.
// Depends on cc20_pkg.
module cc20_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  cc20_pkg::state_t  init_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [511:0]      block_o
);

  cc20_pkg::state_t w_q, w_d, init_q;
  logic [4:0] rnd_q;
  logic       busy_q, done_q;
  logic [127:0] q0, q1, q2, q3;

  always_comb begin
    w_d = w_q;
    if (!rnd_q[0]) begin
      q0 = cc20_pkg::qround(w_q[0], w_q[4], w_q[8],  w_q[12]);
      q1 = cc20_pkg::qround(w_q[1], w_q[5], w_q[9],  w_q[13]);
      q2 = cc20_pkg::qround(w_q[2], w_q[6], w_q[10], w_q[14]);
      q3 = cc20_pkg::qround(w_q[3], w_q[7], w_q[11], w_q[15]);
      {w_d[0], w_d[4], w_d[8],  w_d[12]} = q0;
      {w_d[1], w_d[5], w_d[9],  w_d[13]} = q1;
      {w_d[2], w_d[6], w_d[10], w_d[14]} = q2;
      {w_d[3], w_d[7], w_d[11], w_d[15]} = q3;
    end else begin
      q0 = cc20_pkg::qround(w_q[0], w_q[5], w_q[10], w_q[15]);
      q1 = cc20_pkg::qround(w_q[1], w_q[6], w_q[11], w_q[12]);
      q2 = cc20_pkg::qround(w_q[2], w_q[7], w_q[8],  w_q[13]);
      q3 = cc20_pkg::qround(w_q[3], w_q[4], w_q[9],  w_q[14]);
      {w_d[0], w_d[5], w_d[10], w_d[15]} = q0;
      {w_d[1], w_d[6], w_d[11], w_d[12]} = q1;
      {w_d[2], w_d[7], w_d[8],  w_d[13]} = q2;
      {w_d[3], w_d[4], w_d[9],  w_d[14]} = q3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 5'd1;
        if (rnd_q == 5'd19) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      w_q    <= init_i;
      init_q <= init_i;
    end else if (busy_q) begin
      w_q <= w_d;
    end
  end

  // feed-forward add; block_o is valid while done_o is high
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      block_o[32*i +: 32] = w_q[i] + init_q[i];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without busy");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> done_q) else $error("busy dropped without done");

endmodule

>>> rtl/cc20_front.sv
// Front end: accepts bytes, tracks block position and counter, queues words.
// Depends on cc20_pkg.
module cc20_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_in_i,
  input  logic                 last_in_i,
  input  logic [31:0]          start_ctr_i,
  output logic                 q_valid_o,
  input  logic                 q_pop_i,
  output cc20_pkg::qword_t     q_word_o,
  output logic                 gen_req_o,
  output logic [31:0]          gen_ctr_o,
  input  logic                 gen_ack_i
);

  localparam int unsigned PtrW = $clog2(cc20_pkg::QDepth);

  cc20_pkg::qword_t fifo_q [cc20_pkg::QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic [cc20_pkg::PosW-1:0] pos_q;
  logic [31:0] ctr_q;
  logic [31:0] gen_ctr_q;
  logic        started_q;
  logic        pend_q;     // a block request not yet taken by the generator
  logic        push, pop;
  logic [31:0] cur_ctr;

  assign cur_ctr    = started_q ? ctr_q : start_ctr_i;
  // a byte that opens a block needs the generator to take its request
  assign in_stall_o = (cnt_q == cc20_pkg::QDepth[PtrW:0]) || pend_q;
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_valid_o  = cnt_q != '0;
  assign q_word_o   = fifo_q[rd_q];
  assign gen_req_o  = pend_q;
  assign gen_ctr_o  = gen_ctr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
      pos_q <= '0; ctr_q <= '0; started_q <= 1'b0; pend_q <= 1'b0;
      gen_ctr_q <= '0;
    end else begin
      if (gen_ack_i) pend_q <= 1'b0;
      if (push) begin
        wr_q <= wr_q + 1'b1;
        if (pos_q == '0) begin
          pend_q    <= 1'b1;
          gen_ctr_q <= cur_ctr;
        end
        pos_q <= pos_q + 1'b1;
        ctr_q <= (pos_q == '1) ? cur_ctr + 32'd1 : cur_ctr;
        started_q <= 1'b1;
        if (last_in_i) begin
          pos_q <= '0;
          started_q <= 1'b0;
        end
      end
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + {{PtrW{1'b0}}, push} - {{PtrW{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= '{data: data_in_i, last: last_in_i, new_blk: pos_q == '0};
  end

  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cc20_pkg::QDepth[PtrW:0]) else $error("queue overflow");
  a_req_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && !gen_ack_i |=> pend_q) else $error("request dropped");
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !started_q |-> pos_q == '0) else $error("position not cleared");

endmodule

>>> rtl/cc20_back.sv
// Back end: runs block generation, holds keystream, XORs bytes into output reg.
// Depends on cc20_pkg, cc20_core.
module cc20_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [cc20_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cc20_pkg::CfgDataW-1:0] cfg_data_i,
  output logic [31:0]          start_ctr_o,
  input  logic                 gen_req_i,
  input  logic [31:0]          gen_ctr_i,
  output logic                 gen_ack_o,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  cc20_pkg::qword_t     q_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           data_out_o,
  output logic                 last_out_o
);

  logic [63:0] k01_q, k23_q, k45_q, k67_q, n01_q;
  logic [31:0] n2_q, start_q;
  cc20_pkg::state_t init;
  logic core_busy, core_done;
  logic [511:0] core_blk;
  // two keystream slots: next block is made while the current one drains
  logic [511:0] ks_q [2];
  logic [1:0]   ks_full_q;
  logic         gen_slot_q, use_slot_q;
  logic         start;
  logic         need_swap, can_take;
  logic [cc20_pkg::PosW-1:0] bpos_q;
  logic         ovalid_q;
  logic [7:0]   kbyte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k01_q <= '0; k23_q <= '0; k45_q <= '0; k67_q <= '0; n01_q <= '0;
      n2_q <= '0; start_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cc20_pkg::RegKey01:   k01_q   <= cfg_data_i;
        cc20_pkg::RegKey23:   k23_q   <= cfg_data_i;
        cc20_pkg::RegKey45:   k45_q   <= cfg_data_i;
        cc20_pkg::RegKey67:   k67_q   <= cfg_data_i;
        cc20_pkg::RegNonce01: n01_q   <= cfg_data_i;
        cc20_pkg::RegNonce2:  n2_q    <= cfg_data_i[31:0];
        cc20_pkg::RegStart:   start_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end
  assign start_ctr_o = start_q;

  assign init = {n2_q, n01_q[63:32], n01_q[31:0], gen_ctr_i,
                 k67_q[63:32], k67_q[31:0], k45_q[63:32], k45_q[31:0],
                 k23_q[63:32], k23_q[31:0], k01_q[63:32], k01_q[31:0],
                 cc20_pkg::Sigma3, cc20_pkg::Sigma2, cc20_pkg::Sigma1, cc20_pkg::Sigma0};

  // target slot must be free and not the one bytes are read from; before the
  // first swap the read slot is empty but gets cleared by that swap
  assign start     = gen_req_i && !core_busy && !core_done && !ks_full_q[gen_slot_q]
                     && (gen_slot_q != use_slot_q);
  assign gen_ack_o = start;

  cc20_core u_core (
    .clk_i, .rst_ni, .start_i(start), .init_i(init),
    .busy_o(core_busy), .done_o(core_done), .block_o(core_blk)
  );

  assign need_swap = q_word_i.new_blk;
  assign can_take  = q_valid_i && (!ovalid_q || !out_stall_i)
                     && (need_swap ? ks_full_q[!use_slot_q] || (!ks_full_q[use_slot_q]
                         && ks_full_q[use_slot_q ^ 1'b1]) : 1'b1);
  assign q_pop_o   = can_take;

  logic [0:0] rd_slot;
  assign rd_slot = need_swap ? !use_slot_q : use_slot_q;
  logic [cc20_pkg::PosW-1:0] rpos;
  assign rpos  = need_swap ? '0 : bpos_q;
  assign kbyte = ks_q[rd_slot][8*rpos +: 8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ks_full_q <= '0; gen_slot_q <= 1'b0; use_slot_q <= 1'b1;
      bpos_q <= '0; ovalid_q <= 1'b0;
    end else begin
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      if (core_done) begin
        ks_full_q[gen_slot_q] <= 1'b1;
        gen_slot_q <= !gen_slot_q;
      end
      if (can_take) begin
        ovalid_q <= 1'b1;
        bpos_q   <= rpos + 1'b1;
        if (need_swap) begin
          ks_full_q[use_slot_q] <= 1'b0;
          use_slot_q <= !use_slot_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_done) ks_q[gen_slot_q] <= core_blk;
    if (can_take) begin
      data_out_o <= q_word_i.data ^ kbyte;
      last_out_o <= q_word_i.last;
    end
  end
  assign out_valid_o = ovalid_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && out_stall_i |=> ovalid_q) else $error("output lost");
  a_swap_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    can_take && need_swap |-> ks_full_q[!use_slot_q]) else $error("empty slot used");
  a_gen_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_done |-> !ks_full_q[gen_slot_q]) else $error("slot overwritten");

endmodule

>>> rtl/chacha20_stream_cipher_core.sv
// ChaCha20 byte-stream cipher top level.
// Depends on cc20_pkg, cc20_front, cc20_back, cc20_core.
//
//  channel   signals                                  direction
//  input     in_valid_i in_stall_o data_in_i last_in_i  in
//  output    out_valid_o out_stall_i data_out_o last_out_o out
//  config    cfg_we_i cfg_idx_i cfg_data_i           in
//
// Blocks are made on demand: a byte that opens a block waits for the start,
// the round unit and the slot load before it shows on out_valid_o. Other
// bytes show in the cycle after they are taken, one a cycle as long as
// out_stall_i is low.
// Reset is asynchronous and clears all control and config registers.
// Output stall backs up through a two-word queue to in_stall_o, which also
// rises after a block-opening byte and stays high until its request is taken.
module chacha20_stream_cipher_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cc20_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [cc20_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          data_in_i,
  input  logic                                last_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          data_out_o,
  output logic                                last_out_o
);

  logic q_valid, q_pop, gen_req, gen_ack;
  logic [31:0] gen_ctr, start_ctr;
  cc20_pkg::qword_t q_word;

  cc20_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_in_i, .last_in_i,
    .start_ctr_i(start_ctr), .q_valid_o(q_valid), .q_pop_i(q_pop),
    .q_word_o(q_word), .gen_req_o(gen_req), .gen_ctr_o(gen_ctr), .gen_ack_i(gen_ack)
  );

  cc20_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .start_ctr_o(start_ctr), .gen_req_i(gen_req), .gen_ctr_i(gen_ctr),
    .gen_ack_o(gen_ack), .q_valid_i(q_valid), .q_pop_o(q_pop), .q_word_i(q_word),
    .out_valid_o, .out_stall_i, .data_out_o, .last_out_o
  );

endmodule
